// File: design/tlge_pkg.sv
// Shared types and constants for the toroidal life grid engine.
package tlge_pkg;

    localparam int CFG_W          = 7;
    localparam int CNT_W          = 8;
    localparam int CMD_W          = 3;
    localparam int COL_W          = 6;
    localparam int ROW_W          = 6;
    localparam int MAX_WIDTH_DEF  = 64;
    localparam int MAX_HEIGHT_DEF = 64;

    localparam logic CFG_GRID_WIDTH  = 1'b0;
    localparam logic CFG_GRID_HEIGHT = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE  = 3'd0,
        CMD_TOGGLE = 3'd1,
        CMD_READ   = 3'd2,
        CMD_STEP   = 3'd3,
        CMD_FLIP   = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CELL,
        S_STEP,
        S_FLIP,
        S_RESULT
    } t_state;

endpackage

// File: design/tlge_row_unit.sv
// Row update unit: next life generation of one row, or row mirror within the width.
module tlge_row_unit #(
    parameter int MW = tlge_pkg::MAX_WIDTH_DEF
) (
    input  logic                      i_flip,
    input  logic [tlge_pkg::CFG_W-1:0] i_width,
    input  logic [MW-1:0]             i_above,
    input  logic [MW-1:0]             i_here,
    input  logic [MW-1:0]             i_below,
    output logic [MW-1:0]             o_row
);
    import tlge_pkg::*;

    localparam int CW = (MW > 1) ? $clog2(MW) : 1;

    logic [CFG_W-1:0] wm1;
    logic [CW-1:0]    wrap_idx;
    logic [MW-1:0]    rev;
    logic [MW-1:0]    mirrored;
    logic [CFG_W-1:0] shamt;

    assign wm1      = i_width - CFG_W'(1);
    assign wrap_idx = wm1[CW-1:0];
    assign shamt    = CFG_W'(MW) - i_width;
    assign mirrored = rev >> shamt;

    genvar x;
    generate
        for (x = 0; x < MW; x++) begin : g_lane
            logic       al, ac, ar, hl, hr, bl, bc, br;
            logic       at_right;
            logic [3:0] n;
            logic       alive;
            logic       in_rng;

            assign rev[x]   = i_here[MW-1-x];
            assign at_right = (CFG_W'(x + 1) == i_width);
            assign in_rng   = (CFG_W'(x) < i_width);

            if (x == 0) begin : g_left_wrap
                assign al = i_above[wrap_idx];
                assign hl = i_here[wrap_idx];
                assign bl = i_below[wrap_idx];
            end else begin : g_left
                assign al = i_above[x-1];
                assign hl = i_here[x-1];
                assign bl = i_below[x-1];
            end

            if (x == MW - 1) begin : g_right_wrap
                assign ar = i_above[0];
                assign hr = i_here[0];
                assign br = i_below[0];
            end else begin : g_right
                assign ar = at_right ? i_above[0] : i_above[x+1];
                assign hr = at_right ? i_here[0]  : i_here[x+1];
                assign br = at_right ? i_below[0] : i_below[x+1];
            end

            assign ac    = i_above[x];
            assign bc    = i_below[x];
            assign n     = 4'(al) + 4'(ac) + 4'(ar) + 4'(hl) + 4'(hr)
                         + 4'(bl) + 4'(bc) + 4'(br);
            assign alive = (n == 4'd3) || (i_here[x] && (n == 4'd2));

            assign o_row[x] = !in_rng ? i_here[x] : (i_flip ? mirrored[x] : alive);
        end
    endgenerate

endmodule

// File: design/tlge_grid_mem.sv
// Cell row memory: one write and one registered read per cycle, rows read empty until written.
module tlge_grid_mem #(
    parameter int MW    = tlge_pkg::MAX_WIDTH_DEF,
    parameter int DEPTH = tlge_pkg::MAX_HEIGHT_DEF,
    parameter int AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [MW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [MW-1:0] o_rdata
);
    logic [MW-1:0]    r_mem [DEPTH];
    logic [DEPTH-1:0] r_row_vld;
    logic [MW-1:0]    r_rdata;
    logic             r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (i_we) begin
                r_row_vld[i_waddr] <= 1'b1;
            end
            r_rd_vld <= r_row_vld[i_raddr];
        end
    end

    assign o_rdata = r_rd_vld ? r_rdata : '0;

endmodule

// File: design/toroidal_life_grid_engine.sv
// Top level: toroidal B3/S23 life grid with cell access, generation step and row mirror.
// One command is taken at a time; o_ready is high only while the engine is idle. Timing is
// set by the single row memory, which reads one row and writes one row per cycle, and by the
// row update unit that handles one row per cycle. Write, toggle and read pass through a cell
// state and then the result state; coordinate errors and unused command codes go straight
// to the result state; flip mirrors the H rows in use one by one, and a generation step
// rewrites every row in use, H being the height in use. The engine is idle again at the edge
// at which the result beat shows if the result register is free, else when the waiting beat
// is taken. After reset the grid reads all empty at once; no clearing pass is needed.
module toroidal_life_grid_engine #(
    parameter int MAX_WIDTH  = tlge_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = tlge_pkg::MAX_HEIGHT_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [tlge_pkg::CMD_W-1:0] i_command,
    input  logic [tlge_pkg::COL_W-1:0] i_column,
    input  logic [tlge_pkg::ROW_W-1:0] i_row_index,
    input  logic                       i_cell_value,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic                       o_cell_alive,
    output logic                       o_out_of_range,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_index,
    input  logic [tlge_pkg::CFG_W-1:0] i_cfg_data
);
    import tlge_pkg::*;

    localparam int CFG_MAX = (1 << CFG_W) - 1;
    localparam int DEPTH   = (MAX_HEIGHT < CFG_MAX) ? MAX_HEIGHT : CFG_MAX;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int MW      = MAX_WIDTH;
    localparam int CW      = (MW > 1) ? $clog2(MW) : 1;

    t_state           r_state, n_state;
    t_cmd             r_cmd, n_cmd;
    logic [CW-1:0]    r_col, n_col;
    logic [AW-1:0]    r_row, n_row;
    logic             r_val, n_val;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [MW-1:0]    r_prev, n_prev;
    logic [MW-1:0]    r_here, n_here;
    logic [MW-1:0]    r_first, n_first;
    logic             r_res_alive, n_res_alive;
    logic             r_res_oor, n_res_oor;
    logic             r_out_vld, n_out_vld;
    logic             r_out_alive, n_out_alive;
    logic             r_out_oor, n_out_oor;
    logic [CFG_W-1:0] r_cfg_w;
    logic [CFG_W-1:0] r_cfg_h;

    logic [CFG_W-1:0] uw;
    logic [CFG_W-1:0] uh;
    logic [CNT_W-1:0] h8;
    logic [CNT_W-1:0] k;
    logic [CNT_W-1:0] rd_cnt;
    logic [CNT_W-1:0] wr_cnt;
    logic [CNT_W-1:0] row_ext;
    t_cmd             in_cmd;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [MW-1:0]    mem_wdata;
    logic [AW-1:0]    mem_raddr;
    logic [MW-1:0]    mem_rdata;

    logic             unit_flip;
    logic [MW-1:0]    unit_here;
    logic [MW-1:0]    unit_below;
    logic [MW-1:0]    unit_row;
    logic             cell_bit;
    logic             cell_new;

    assign uw = (r_cfg_w == '0) ? CFG_W'(1)
              : ((r_cfg_w > CFG_W'(MW)) ? CFG_W'(MW) : r_cfg_w);
    assign uh = (r_cfg_h == '0) ? CFG_W'(1)
              : ((r_cfg_h > CFG_W'(DEPTH)) ? CFG_W'(DEPTH) : r_cfg_h);
    assign h8      = CNT_W'(uh);
    assign k       = r_cnt - CNT_W'(1);
    assign in_cmd  = t_cmd'(i_command);
    assign row_ext = CNT_W'(i_row_index);
    assign o_ready = (r_state == S_IDLE);

    assign o_valid        = r_out_vld;
    assign o_cell_alive   = r_out_alive;
    assign o_out_of_range = r_out_oor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= CFG_W'(64);
            r_cfg_h <= CFG_W'(64);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GRID_WIDTH:  r_cfg_w <= i_cfg_data;
                CFG_GRID_HEIGHT: r_cfg_h <= i_cfg_data;
                default:         r_cfg_w <= r_cfg_w;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_col       <= n_col;
        r_row       <= n_row;
        r_val       <= n_val;
        r_prev      <= n_prev;
        r_here      <= n_here;
        r_first     <= n_first;
        r_res_alive <= n_res_alive;
        r_res_oor   <= n_res_oor;
        r_out_alive <= n_out_alive;
        r_out_oor   <= n_out_oor;
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_col       = r_col;
        n_row       = r_row;
        n_val       = r_val;
        n_cnt       = r_cnt;
        n_prev      = r_prev;
        n_here      = r_here;
        n_first     = r_first;
        n_res_alive = r_res_alive;
        n_res_oor   = r_res_oor;
        n_out_vld   = r_out_vld && !i_ready;
        n_out_alive = r_out_alive;
        n_out_oor   = r_out_oor;

        mem_we     = 1'b0;
        mem_waddr  = r_row;
        mem_wdata  = mem_rdata;
        mem_raddr  = r_row;
        unit_flip  = (r_state == S_FLIP);
        unit_here  = (r_state == S_FLIP) ? mem_rdata : r_here;
        unit_below = mem_rdata;
        cell_bit   = mem_rdata[r_col];
        cell_new   = cell_bit;
        rd_cnt     = (r_cnt == '0) ? (h8 - CNT_W'(1)) : k;
        wr_cnt     = k - CNT_W'(2);

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_cmd       = in_cmd;
                    n_col       = i_column[CW-1:0];
                    n_row       = row_ext[AW-1:0];
                    n_val       = i_cell_value;
                    n_cnt       = '0;
                    n_res_alive = 1'b0;
                    n_res_oor   = 1'b0;
                    mem_raddr   = row_ext[AW-1:0];
                    unique case (in_cmd) inside
                        CMD_WRITE, CMD_TOGGLE, CMD_READ: begin
                            if ((CFG_W'(i_column) >= uw) || (CFG_W'(i_row_index) >= uh)) begin
                                n_res_oor = 1'b1;
                                n_state   = S_RESULT;
                            end else begin
                                n_state = S_CELL;
                            end
                        end
                        CMD_STEP: n_state = S_STEP;
                        CMD_FLIP: n_state = S_FLIP;
                        default:  n_state = S_RESULT;
                    endcase
                end
            end
            S_CELL: begin
                if (r_cmd == CMD_WRITE) begin
                    cell_new = r_val;
                end else if (r_cmd == CMD_TOGGLE) begin
                    cell_new = !cell_bit;
                end
                mem_we             = (r_cmd == CMD_WRITE) || (r_cmd == CMD_TOGGLE);
                mem_wdata[r_col]   = cell_new;
                n_res_alive        = cell_new;
                n_state            = S_RESULT;
            end
            S_STEP: begin
                // Rows arrive H-1, 0, 1, ... ; row y is rewritten once row y+1 is in.
                mem_raddr = rd_cnt[AW-1:0];
                n_cnt     = r_cnt + CNT_W'(1);
                if (r_cnt == h8 + CNT_W'(2)) begin
                    unit_below = r_first;
                    mem_we     = 1'b1;
                    wr_cnt     = h8 - CNT_W'(1);
                    mem_waddr  = wr_cnt[AW-1:0];
                    mem_wdata  = unit_row;
                    n_state    = S_RESULT;
                end else if (r_cnt != '0) begin
                    if (k == '0) begin
                        n_prev = mem_rdata;
                    end else if (k == CNT_W'(1)) begin
                        n_here  = mem_rdata;
                        n_first = mem_rdata;
                    end else if (k <= h8) begin
                        mem_we    = 1'b1;
                        mem_waddr = wr_cnt[AW-1:0];
                        mem_wdata = unit_row;
                        n_prev    = r_here;
                        n_here    = mem_rdata;
                    end
                end
            end
            S_FLIP: begin
                mem_raddr = r_cnt[AW-1:0];
                n_cnt     = r_cnt + CNT_W'(1);
                if (r_cnt != '0) begin
                    mem_we    = 1'b1;
                    mem_waddr = k[AW-1:0];
                    mem_wdata = unit_row;
                end
                if (r_cnt == h8) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (!r_out_vld || i_ready) begin
                    n_out_vld   = 1'b1;
                    n_out_alive = r_res_alive;
                    n_out_oor   = r_res_oor;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    tlge_grid_mem #(
        .MW    (MW),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    tlge_row_unit #(
        .MW (MW)
    ) u_row_unit (
        .i_flip  (unit_flip),
        .i_width (uw),
        .i_above (r_prev),
        .i_here  (unit_here),
        .i_below (unit_below),
        .o_row   (unit_row)
    );

endmodule

// File: design/tlge_checker.sv
// Port-level checks for the life grid engine, bound to the top level.
module tlge_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_ready,
    input logic o_valid,
    input logic i_ready,
    input logic o_cell_alive,
    input logic o_out_of_range
);

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("engine ready right after taking a beat");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_cell_alive) && $stable(o_out_of_range)))
        else $error("stalled result beat changed");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_cell_alive && o_out_of_range))
        else $error("out-of-range beat reports a live cell");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat valid after reset");

endmodule

bind toroidal_life_grid_engine tlge_checker u_tlge_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_cell_alive   (o_cell_alive),
    .o_out_of_range (o_out_of_range)
);

// File: dv/toroidal_life_grid_engine_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the toroidal life grid engine: cell access, step, flip, sizes.
module toroidal_life_grid_engine_tb;
    import tlge_pkg::*;

    localparam int GRID_COLS     = MAX_WIDTH_DEF;
    localparam int GRID_ROWS     = MAX_HEIGHT_DEF;
    localparam int SETTLE_CYCLES = GRID_ROWS + 16;
    localparam int IDLE_PAUSE    = 4;
    localparam int CMD_CODES     = 2 ** CMD_W;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        int unsigned      seq;
        logic             cell_alive;
        logic             out_of_range;
    } t_cell_result;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_valid        = 1'b0;
    logic               o_ready;
    logic [CMD_W-1:0]   i_command      = CMD_READ;
    logic [COL_W-1:0]   i_column       = '0;
    logic [ROW_W-1:0]   i_row_index    = '0;
    logic               i_cell_value   = 1'b0;
    logic               o_valid;
    logic               i_ready        = 1'b0;
    logic               o_cell_alive;
    logic               o_out_of_range;
    logic               i_cfg_we       = 1'b0;
    logic               i_cfg_index    = CFG_GRID_WIDTH;
    logic [CFG_W-1:0]   i_cfg_data     = '0;

    // shadow grid and size registers
    logic [GRID_COLS-1:0] life_rows [GRID_ROWS];
    logic [CFG_W-1:0]     width_reg  = CFG_W'(GRID_COLS);
    logic [CFG_W-1:0]     height_reg = CFG_W'(GRID_ROWS);

    t_cell_result pending_results [$];
    t_cell_result beat_want;
    int unsigned  beats_sent = 0;
    int           err_count  = 0;
    int           stall_pct  = 10;

    toroidal_life_grid_engine dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_command      (i_command),
        .i_column       (i_column),
        .i_row_index    (i_row_index),
        .i_cell_value   (i_cell_value),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_cell_alive   (o_cell_alive),
        .o_out_of_range (o_out_of_range),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic int used_width();
        if (width_reg == 0) return 1;
        if (width_reg > GRID_COLS) return GRID_COLS;
        return int'(width_reg);
    endfunction

    function automatic int used_height();
        if (height_reg == 0) return 1;
        if (height_reg > GRID_ROWS) return GRID_ROWS;
        return int'(height_reg);
    endfunction

    // B3/S23 over the active region, torus wrap, every cell from the old generation
    function automatic void advance_generation();
        logic [GRID_COLS-1:0] old_rows [GRID_ROWS];
        logic [GRID_COLS-1:0] above, here, below;
        int w, h, xl, xr, n;
        w = used_width();
        h = used_height();
        old_rows = life_rows;
        for (int y = 0; y < h; y++) begin
            above = old_rows[(y + h - 1) % h];
            here  = old_rows[y];
            below = old_rows[(y + 1) % h];
            for (int x = 0; x < w; x++) begin
                xl = (x + w - 1) % w;
                xr = (x + 1) % w;
                n = int'(above[xl]) + int'(above[x]) + int'(above[xr])
                  + int'(here[xl]) + int'(here[xr])
                  + int'(below[xl]) + int'(below[x]) + int'(below[xr]);
                life_rows[y][x] = here[x] ? (n == 2 || n == 3) : (n == 3);
            end
        end
    endfunction

    function automatic void mirror_rows();
        int w, h;
        logic t;
        w = used_width();
        h = used_height();
        for (int y = 0; y < h; y++) begin
            for (int x = 0; x < w / 2; x++) begin
                t = life_rows[y][x];
                life_rows[y][x] = life_rows[y][w - 1 - x];
                life_rows[y][w - 1 - x] = t;
            end
        end
    endfunction

    function automatic t_cell_result apply_command(logic [CMD_W-1:0] cmd, logic [COL_W-1:0] col,
                                                   logic [ROW_W-1:0] row, logic val);
        t_cell_result r;
        r = '0;
        r.cmd = cmd;
        r.seq = beats_sent;
        case (cmd)
            CMD_WRITE, CMD_TOGGLE, CMD_READ: begin
                if (int'(col) >= used_width() || int'(row) >= used_height()) begin
                    r.out_of_range = 1'b1;
                end else begin
                    if (cmd == CMD_WRITE) life_rows[row][col] = val;
                    else if (cmd == CMD_TOGGLE) life_rows[row][col] = ~life_rows[row][col];
                    r.cell_alive = life_rows[row][col];
                end
            end
            CMD_STEP: advance_generation();
            CMD_FLIP: mirror_rows();
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what);
        err_count++;
        $display("%0t MISMATCH %s", $realtime, what);
    endtask

    task automatic send_command(logic [CMD_W-1:0] cmd, logic [COL_W-1:0] col,
                                logic [ROW_W-1:0] row, logic val);
        while ($urandom_range(99) < stall_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_command    <= cmd;
        i_column     <= col;
        i_row_index  <= row;
        i_cell_value <= val;
        do @(posedge i_clk); while (!o_ready);
        pending_results.push_back(apply_command(cmd, col, row, val));
        beats_sent++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (IDLE_PAUSE) @(posedge i_clk);
    endtask

    task automatic set_size(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_GRID_WIDTH;
        i_cfg_data  <= w;
        @(posedge i_clk);
        width_reg    = w;
        i_cfg_index <= CFG_GRID_HEIGHT;
        i_cfg_data  <= h;
        @(posedge i_clk);
        height_reg = h;
        i_cfg_we  <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result beat with nothing outstanding");
            end else begin
                beat_want = pending_results.pop_front();
                if (o_cell_alive !== beat_want.cell_alive)
                    report_mismatch($sformatf("beat %0d cmd %0d cell_alive %b want %b",
                        beat_want.seq, beat_want.cmd, o_cell_alive, beat_want.cell_alive));
                if (o_out_of_range !== beat_want.out_of_range)
                    report_mismatch($sformatf("beat %0d cmd %0d out_of_range %b want %b",
                        beat_want.seq, beat_want.cmd, o_out_of_range, beat_want.out_of_range));
            end
        end
    end

    task automatic test_cell_access();
        send_command(CMD_READ,   6'd0,  6'd0,  1'b0);
        send_command(CMD_WRITE,  6'd63, 6'd63, 1'b1);
        send_command(CMD_READ,   6'd63, 6'd63, 1'b0);
        send_command(CMD_TOGGLE, 6'd0,  6'd0,  1'b0);
        send_command(CMD_TOGGLE, 6'd0,  6'd0,  1'b1);
        send_command(CMD_WRITE,  6'd21, 6'd42, 1'b1);
        send_command(CMD_WRITE,  6'd21, 6'd42, 1'b0);
        send_command(CMD_READ,   6'd42, 6'd21, 1'b0);
    endtask

    task automatic test_unused_codes();
        for (int c = int'(CMD_FLIP) + 1; c < CMD_CODES; c++)
            send_command(CMD_W'(c), 6'd63, 6'd0, 1'b1);
    endtask

    // blinker across the left/right seam, then mirrored
    task automatic test_step_and_flip();
        send_command(CMD_WRITE, 6'd63, 6'd5, 1'b1);
        send_command(CMD_WRITE, 6'd0,  6'd5, 1'b1);
        send_command(CMD_WRITE, 6'd1,  6'd5, 1'b1);
        send_command(CMD_STEP,  6'd0,  6'd0, 1'b0);
        send_command(CMD_READ,  6'd0,  6'd4, 1'b0);
        send_command(CMD_FLIP,  6'd0,  6'd0, 1'b0);
        send_command(CMD_READ,  6'd63, 6'd6, 1'b0);
    endtask

    // zero registers mean a single cell that sees itself eight times
    task automatic test_tiny_grid();
        set_size('0, '0);
        send_command(CMD_WRITE, 6'd0, 6'd0, 1'b1);
        send_command(CMD_STEP,  6'd0, 6'd0, 1'b0);
        send_command(CMD_READ,  6'd0, 6'd0, 1'b0);
        send_command(CMD_WRITE, 6'd1, 6'd0, 1'b1);
        send_command(CMD_READ,  6'd0, 6'd1, 1'b0);
    endtask

    task automatic test_saturated_size();
        set_size('1, '1);
        send_command(CMD_READ, 6'd63, 6'd63, 1'b0);
        send_command(CMD_STEP, 6'd0,  6'd0,  1'b0);
        send_command(CMD_FLIP, 6'd0,  6'd0,  1'b0);
    endtask

    function automatic logic [CFG_W-1:0] random_size();
        case ($urandom_range(7))
            0:       return CFG_W'($urandom_range(127));
            1:       return CFG_W'(GRID_COLS);
            2:       return CFG_W'($urandom_range(3));
            default: return CFG_W'($urandom_range(16, 4));
        endcase
    endfunction

    task automatic test_random_soup();
        int w, h, pick;
        logic [CMD_W-1:0] cmd;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        for (int phase = 0; phase < 8; phase++) begin
            stall_pct = (phase == 3) ? 0 : 10;
            set_size(random_size(), random_size());
            w = used_width();
            h = used_height();
            for (int k = 0; k < 100; k++) begin
                pick = $urandom_range(99);
                if (pick < 30)      cmd = CMD_WRITE;
                else if (pick < 45) cmd = CMD_TOGGLE;
                else if (pick < 72) cmd = CMD_READ;
                else if (pick < 84) cmd = CMD_STEP;
                else if (pick < 90) cmd = CMD_FLIP;
                else if (pick < 93) cmd = CMD_W'($urandom_range(CMD_CODES - 1, int'(CMD_FLIP) + 1));
                else                cmd = CMD_READ;
                if ($urandom_range(99) < 15) begin
                    col = COL_W'($urandom_range(63));
                    row = ROW_W'($urandom_range(63));
                end else begin
                    col = COL_W'($urandom_range(w - 1));
                    row = ROW_W'($urandom_range(h - 1));
                end
                send_command(cmd, col, row, 1'($urandom_range(1)));
            end
        end
        stall_pct = 10;
    endtask

    initial begin
        foreach (life_rows[y]) life_rows[y] = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_cell_access();
        test_unused_codes();
        test_step_and_flip();
        test_tiny_grid();
        test_saturated_size();
        test_random_soup();
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (err_count == 0 && pending_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
